[rtl/plist_pkg.sv]
// plist_pkg: shared sizes, command codes and status codes of the positional list store
`timescale 1ns / 1ps
`default_nettype none

package plist_pkg;

   // list sizing
   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int OP_W     = 3;
   localparam int STAT_W   = 2;

   // command codes
   localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT    = 3'd1;
   localparam logic [OP_W-1:0] OP_DELETE    = 3'd2;
   localparam logic [OP_W-1:0] OP_READ      = 3'd3;
   localparam logic [OP_W-1:0] OP_OVERWRITE = 3'd4;
   localparam logic [OP_W-1:0] OP_FIND      = 3'd5;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE    = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

`default_nettype wire

[rtl/plist_if.sv]
// plist_if: command and response channel interfaces of the positional list store
`timescale 1ns / 1ps
`default_nettype none

interface plist_req_if;
   import plist_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic [CNT_W-1:0]         position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, op, position, value, input ready);
   modport sink   (input valid, op, position, value, output ready);
endinterface

interface plist_rsp_if;
   import plist_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STAT_W-1:0]        status;
   logic signed [DATA_W-1:0] read_value;
   logic [IDX_W-1:0]         found_index;
   logic [CNT_W-1:0]         length;

   modport source (output valid, status, read_value, found_index, length, input ready);
   modport sink   (input valid, status, read_value, found_index, length, output ready);
endinterface

`default_nettype wire

[rtl/plist_ram.sv]
// plist_ram: generic simple dual-port ram with one write port and a registered read port
`timescale 1ns / 1ps
`default_nettype none

module plist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/positional_list_store.sv]
// positional_list_store: top level of the positional list store
// The block keeps an ordered list of up to CAPACITY signed 32-bit words in a
// single element ram and runs one command at a time. Append, overwrite, the
// unused command codes and every rejected command go from S_IDLE straight to
// S_RESP, which puts their response word in the output register once it is
// free, and a read passes through S_DRAIN first. Insert and delete move every
// word behind the position by one place, one word per cycle through the ram
// read and write ports. An insert at the tail writes the new word at once,
// and a delete of the last word only shortens the list. A find scans from
// position 0, one word per cycle, and stops at the first match, or reports
// not found when nothing matches. The element ram walk sets the rate: an
// insert at the head of a list of 63 words moves all 63. A response word that
// is held by the sink holds the block in S_RESP. A new command is taken while
// the previous response word still waits in the output register. Elements
// need no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_store (
   input wire logic  clock,
   input wire logic  reset,
   plist_req_if.sink   req_chan,
   plist_rsp_if.source rsp_chan
);
   import plist_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_DRAIN,
      S_PUT,
      S_RESP
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]  last_ff, last_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   logic [STAT_W-1:0] res_status_ff, res_status_in;
   logic [DATA_W-1:0] res_read_ff, res_read_in;
   logic [IDX_W-1:0]  res_found_ff, res_found_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_read_ff, rsp_read_in;
   logic [IDX_W-1:0]  rsp_found_ff, rsp_found_in;
   logic [CNT_W-1:0]  rsp_length_ff, rsp_length_in;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] rd_data;

   logic              accept;
   logic              rsp_free;
   logic              is_full;
   logic              in_range;
   logic              hit;

   // element store
   plist_ram #(
      .WIDTH(DATA_W),
      .DEPTH(CAPACITY)
   ) u_elem_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // channel handshakes
   assign req_chan.ready       = (state_ff == S_IDLE);
   assign accept               = req_chan.valid && req_chan.ready;
   assign rsp_free             = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.read_value  = rsp_read_ff;
   assign rsp_chan.found_index = rsp_found_ff;
   assign rsp_chan.length      = rsp_length_ff;

   assign is_full  = (count_ff >= CNT_W'(CAPACITY));
   assign in_range = (req_chan.position < count_ff);
   assign hit      = pend_valid_ff && (rd_data == val_ff);

   // command sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      rd_idx_in     = rd_idx_ff;
      last_in       = last_ff;
      pend_valid_in = 1'b0;
      pend_idx_in   = rd_idx_ff;
      res_status_in = res_status_ff;
      res_read_in   = res_read_ff;
      res_found_in  = res_found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_length_in = rsp_length_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = val_ff;
      rd_en         = 1'b0;
      rd_addr       = rd_idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in         = req_chan.op;
               pos_in        = req_chan.position[IDX_W-1:0];
               val_in        = req_chan.value;
               res_status_in = ST_OK;
               res_read_in   = '0;
               res_found_in  = '0;
               state_in      = S_RESP;
               case (req_chan.op)
                  OP_APPEND: begin
                     if (is_full) begin
                        res_status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[IDX_W-1:0];
                        wr_data  = req_chan.value;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_INSERT: begin
                     if (req_chan.position > count_ff) begin
                        res_status_in = ST_RANGE;
                     end else if (is_full) begin
                        res_status_in = ST_FULL;
                     end else if (req_chan.position == count_ff) begin
                        wr_en    = 1'b1;
                        wr_addr  = req_chan.position[IDX_W-1:0];
                        wr_data  = req_chan.value;
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        // move the tail up, last word first
                        rd_idx_in = IDX_W'(count_ff - CNT_W'(1));
                        last_in   = req_chan.position[IDX_W-1:0];
                        state_in  = S_WALK;
                     end
                  end
                  OP_DELETE: begin
                     if (!in_range) begin
                        res_status_in = ST_RANGE;
                     end else if (req_chan.position == count_ff - CNT_W'(1)) begin
                        count_in = count_ff - CNT_W'(1);
                     end else begin
                        // move the tail down, first word first
                        rd_idx_in = req_chan.position[IDX_W-1:0] + IDX_W'(1);
                        last_in   = IDX_W'(count_ff - CNT_W'(1));
                        state_in  = S_WALK;
                     end
                  end
                  OP_READ: begin
                     if (!in_range) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        rd_en         = 1'b1;
                        rd_addr       = req_chan.position[IDX_W-1:0];
                        pend_valid_in = 1'b1;
                        pend_idx_in   = req_chan.position[IDX_W-1:0];
                        state_in      = S_DRAIN;
                     end
                  end
                  OP_OVERWRITE: begin
                     if (!in_range) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = req_chan.position[IDX_W-1:0];
                        wr_data = req_chan.value;
                     end
                  end
                  OP_FIND: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_NOTFOUND;
                     end else begin
                        rd_idx_in = '0;
                        last_in   = IDX_W'(count_ff - CNT_W'(1));
                        state_in  = S_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_WALK: begin
            // issue the next read, retire the word read last cycle
            rd_en         = 1'b1;
            rd_addr       = rd_idx_ff;
            pend_valid_in = 1'b1;
            pend_idx_in   = rd_idx_ff;
            if (rd_idx_ff == last_ff) begin
               state_in = S_DRAIN;
            end else if (op_ff == OP_INSERT) begin
               rd_idx_in = rd_idx_ff - IDX_W'(1);
            end else begin
               rd_idx_in = rd_idx_ff + IDX_W'(1);
            end
            if (pend_valid_ff) begin
               case (op_ff)
                  OP_INSERT: begin
                     wr_en   = 1'b1;
                     wr_addr = pend_idx_ff + IDX_W'(1);
                     wr_data = rd_data;
                  end
                  OP_DELETE: begin
                     wr_en   = 1'b1;
                     wr_addr = pend_idx_ff - IDX_W'(1);
                     wr_data = rd_data;
                  end
                  default: begin
                  end
               endcase
            end
            // first match ends the scan early
            if (op_ff == OP_FIND && hit) begin
               res_status_in = ST_OK;
               res_found_in  = pend_idx_ff;
               state_in      = S_RESP;
            end
         end

         S_DRAIN: begin
            // retire the final read
            state_in = S_RESP;
            case (op_ff)
               OP_INSERT: begin
                  wr_en    = 1'b1;
                  wr_addr  = pend_idx_ff + IDX_W'(1);
                  wr_data  = rd_data;
                  state_in = S_PUT;
               end
               OP_DELETE: begin
                  wr_en    = 1'b1;
                  wr_addr  = pend_idx_ff - IDX_W'(1);
                  wr_data  = rd_data;
                  count_in = count_ff - CNT_W'(1);
               end
               OP_FIND: begin
                  if (hit) begin
                     res_status_in = ST_OK;
                     res_found_in  = pend_idx_ff;
                  end else begin
                     res_status_in = ST_NOTFOUND;
                  end
               end
               OP_READ: begin
                  res_read_in = rd_data;
               end
               default: begin
               end
            endcase
         end

         S_PUT: begin
            // new word lands in the freed slot
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = val_ff;
            count_in = count_ff + CNT_W'(1);
            state_in = S_RESP;
         end

         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_read_in   = res_read_ff;
               rsp_found_in  = res_found_ff;
               rsp_length_in = count_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      rd_idx_ff     <= rd_idx_in;
      last_ff       <= last_in;
      pend_idx_ff   <= pend_idx_in;
      res_status_ff <= res_status_in;
      res_read_ff   <= res_read_in;
      res_found_ff  <= res_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_length_ff <= rsp_length_in;
   end

`ifndef SYNTHESIS
   // length never passes capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("list length above capacity");

   // length moves by at most one word per cycle
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff)) ||
                        (count_ff == $past(count_ff) + CNT_W'(1)) ||
                        (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("list length jumped");

   // a walk only runs over a non-empty list
   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (count_ff != '0))
      else $error("walk over empty list");

   // the insert slot is only filled when there is room
   a_put_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUT) |-> (count_ff < CNT_W'(CAPACITY)))
      else $error("insert into full list");

   // a new response word is only loaded into a free output register
   a_rsp_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> rsp_valid_ff &&
         $stable(rsp_status_ff) && $stable(rsp_length_ff))
      else $error("response word overwritten");
`endif

endmodule

`default_nettype wire
